// File: sv/hst_pkg.sv
// Package for the hashed slot table: sizes, request and status codes, the controller
// state type and the probe descriptor shared by the probe unit and the top level.
// Depends on nothing.
`default_nettype none

package hst_pkg;

  localparam int TABLE_SLOTS = 4096;
  localparam int SLOT_W      = 12;
  localparam int LIM_W       = 13;
  localparam int KEY_W       = 48;
  localparam int HASH_W      = 31;
  localparam int ATT_W       = 13;
  localparam int LINE_LOG    = 2;
  localparam int MIN_WIDTH   = 8;
  localparam int BIAS        = (1 << (MIN_WIDTH + LINE_LOG)) - 1;
  // Only the first three probe widths can land inside a table of this size.
  localparam int HASH_ATT    = 12;
  localparam int HLO_W       = MIN_WIDTH + 2;
  localparam int HV_W        = 14;

  localparam logic [HV_W-1:0] BASE_W8  = HV_W'((1 << (MIN_WIDTH + LINE_LOG)) - BIAS);
  localparam logic [HV_W-1:0] BASE_W9  = HV_W'((1 << (MIN_WIDTH + 1 + LINE_LOG)) - BIAS);
  localparam logic [HV_W-1:0] BASE_W10 = HV_W'((1 << (MIN_WIDTH + 2 + LINE_LOG)) - BIAS);

  localparam logic [LIM_W-1:0] LIMIT_MIN   = LIM_W'(1);
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(TABLE_SLOTS);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_NEW     = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_DONE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_READ,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              full;
    logic              skip;
    logic [SLOT_W-1:0] idx;
  } probe_t;

endpackage

`default_nettype wire

// File: sv/hashed_slot_table_insert_top.sv
// Hashed slot table top level: controller, slot RAM and probe unit.
// Depends on hst_pkg, hst_ram and hst_probe.
// After reset the block clears its 4096-slot RAM, one slot a cycle, and stalls its input
// while it does so; configuration writes are taken throughout. It then handles one
// item at a time through the single read port of the slot RAM. An insert inspects slots
// in turn, passing over a fallback attempt that lands on the limit, until it finds its
// key, an empty slot or a full table. A result waits while the output register is still
// occupied by an untaken result. The output register lets the next item be accepted while
// a result is still waiting to be taken.
`default_nettype none

module hashed_slot_table_insert_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_req_type,
  input  wire logic [hst_pkg::KEY_W-1:0]    in_key,
  input  wire logic [hst_pkg::HASH_W-1:0]   in_hash_id,
  input  wire logic [hst_pkg::SLOT_W-1:0]   in_slot,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_status,
  output logic [hst_pkg::SLOT_W-1:0]        out_slot_index,
  output logic [hst_pkg::KEY_W-1:0]         out_read_key,
  output logic                              out_read_valid,
  output logic [hst_pkg::SLOT_W-1:0]        out_top_used,
  input  wire logic                         cfg_wr_en,
  input  wire logic [hst_pkg::LIM_W-1:0]    cfg_wr_data
);
  import hst_pkg::*;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] clr_r;
  logic [LIM_W-1:0]  lim_r;
  logic [SLOT_W-1:0] top_r;
  logic [KEY_W-1:0]  key_r;
  logic [HLO_W-1:0]  hash_r;
  logic [ATT_W-1:0]  att_r;
  logic [SLOT_W-1:0] idx_r;
  status_t           res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [KEY_W-1:0]  res_rkey_r;
  logic              res_rvalid_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [KEY_W-1:0]  out_rkey_r;
  logic              out_rvalid_r;
  logic [SLOT_W-1:0] out_top_r;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;

  probe_t            probe;
  req_t              in_req;
  logic              accept;
  logic              out_free;
  logic              hit;
  logic              empty;

  assign in_req   = req_t'(in_req_type);
  assign accept   = (state_r == ST_IDLE) && in_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign hit      = (ram_rdata == key_r);
  assign empty    = (ram_rdata == '0);

  hst_ram #(
    .DEPTH (TABLE_SLOTS),
    .WIDTH (KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hst_probe u_probe (
    .attempt (att_r),
    .hash_lo (hash_r),
    .limit   (lim_r),
    .probe   (probe)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req == REQ_INSERT && in_key != '0) begin
            state_nxt = ST_PROBE;
          end else if (in_req == REQ_READ) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_PROBE: begin
        if (probe.full) begin
          state_nxt = ST_RESULT;
        end else if (!probe.skip) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = (hit || empty) ? ST_RESULT : ST_PROBE;
      end
      ST_READ: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = in_slot;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_waddr = in_slot;
        ram_we    = in_valid && (in_req == REQ_FREE);
        ram_re    = in_valid && (in_req == REQ_READ);
      end
      ST_PROBE: begin
        ram_raddr = probe.idx;
        ram_re    = !probe.full && !probe.skip;
      end
      ST_CHECK: begin
        ram_waddr = idx_r;
        ram_wdata = key_r;
        ram_we    = empty && !hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      lim_r       <= LIMIT_RESET;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + SLOT_W'(1);
      end
      if (cfg_wr_en) begin
        if (cfg_wr_data == '0) begin
          lim_r <= LIMIT_MIN;
        end else if (cfg_wr_data > LIMIT_RESET) begin
          lim_r <= LIMIT_RESET;
        end else begin
          lim_r <= cfg_wr_data;
        end
      end
      if (state_r == ST_CHECK && empty && !hit && idx_r > top_r) begin
        top_r <= idx_r;
      end
      if (state_r == ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r        <= in_key;
      hash_r       <= in_hash_id[HLO_W-1:0];
      att_r        <= '0;
      res_rkey_r   <= '0;
      res_rvalid_r <= 1'b0;
      if (in_req == REQ_INSERT) begin
        res_status_r <= STAT_FULL;
        res_slot_r   <= '0;
      end else begin
        res_status_r <= STAT_DONE;
        res_slot_r   <= in_slot;
      end
    end
    if (state_r == ST_PROBE) begin
      if (probe.skip) begin
        att_r <= att_r + ATT_W'(1);
      end else begin
        idx_r <= probe.idx;
      end
    end
    if (state_r == ST_CHECK) begin
      if (hit) begin
        res_status_r <= STAT_PRESENT;
        res_slot_r   <= idx_r;
      end else if (empty) begin
        res_status_r <= STAT_NEW;
        res_slot_r   <= idx_r;
      end else begin
        att_r <= att_r + ATT_W'(1);
      end
    end
    if (state_r == ST_READ) begin
      res_rkey_r   <= ram_rdata;
      res_rvalid_r <= !empty;
    end
    if (state_r == ST_RESULT && out_free) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_rkey_r   <= res_rkey_r;
      out_rvalid_r <= res_rvalid_r;
      out_top_r    <= top_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;
  assign out_read_key   = out_rkey_r;
  assign out_read_valid = out_rvalid_r;
  assign out_top_used   = out_top_r;

  a_probe_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE && !probe.full && !probe.skip) |-> (LIM_W'(probe.idx) < lim_r))
    else $error("probe slot at or above the limit");

  a_top_follows_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && empty && !hit) |=> (top_r >= $past(idx_r)))
    else $error("top mark below a newly filled slot");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && out_valid_r && out_stall) |=> (state_r == ST_RESULT))
    else $error("result left while the output register was occupied");

  a_clear_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> (state_r == ST_CLEAR || state_r == ST_IDLE) && !out_valid_r)
    else $error("activity during the clearing pass");

endmodule

`default_nettype wire

// File: sv/hst_ram.sv
// Single-clock RAM with one write port and one read port, read data registered.
// Generic; depends on nothing.
`default_nettype none

module hst_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 48,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/hst_probe.sv
// Probe address unit: turns an attempt number, the low hash bits and the slot limit
// into the slot to probe, a skip or a full indication. Depends on hst_pkg.
`default_nettype none

module hst_probe (
  input  wire logic [hst_pkg::ATT_W-1:0] attempt,
  input  wire logic [hst_pkg::HLO_W-1:0] hash_lo,
  input  wire logic [hst_pkg::LIM_W-1:0] limit,
  output hst_pkg::probe_t                probe
);
  import hst_pkg::*;

  logic [HV_W-1:0] hv;
  logic [HV_W-1:0] fb;
  logic            use_hash;

  always_comb begin
    unique case (attempt[3:2])
      2'd0:    hv = BASE_W8  + HV_W'({hash_lo[7:0], attempt[1:0]});
      2'd1:    hv = BASE_W9  + HV_W'({hash_lo[8:0], attempt[1:0]});
      2'd2:    hv = BASE_W10 + HV_W'({hash_lo[9:0], attempt[1:0]});
      default: hv = '0;
    endcase
  end

  assign use_hash = (attempt < ATT_W'(HASH_ATT)) && (hv < HV_W'(limit));
  assign fb       = HV_W'(limit) - HV_W'(attempt);

  always_comb begin
    probe = '0;
    priority if (use_hash) begin
      probe.idx = hv[SLOT_W-1:0];
    end else if (attempt > limit) begin
      probe.full = 1'b1;
    end else if (attempt == '0) begin
      probe.skip = 1'b1;
    end else begin
      probe.idx = fb[SLOT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: bench/hashed_slot_table_insert_top_test.sv
// Self-checking testbench for hashed_slot_table_insert_top: inserts, frees and reads under
// random handshake gaps, checked against an in-bench model of the slot table.
// Depends on hst_pkg and the hashed_slot_table_insert_top RTL.
module hashed_slot_table_insert_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hst_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 140;
  localparam int PHASES         = 12;
  localparam int TAIL_CYCLES    = 40;

  typedef struct {
    req_t              req;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
    logic [SLOT_W-1:0] slot;
  } table_request_t;

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] slot_index;
    logic [KEY_W-1:0]  read_key;
    logic              read_valid;
    logic [SLOT_W-1:0] top_used;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [KEY_W-1:0] in_key = '0;
  logic [HASH_W-1:0] in_hash_id = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [SLOT_W-1:0] out_slot_index;
  logic [KEY_W-1:0] out_read_key;
  logic out_read_valid;
  logic [SLOT_W-1:0] out_top_used;
  logic cfg_wr_en = 1'b0;
  logic [LIM_W-1:0] cfg_wr_data = '0;

  bit [KEY_W-1:0] model_keys [0:TABLE_SLOTS-1];
  bit [SLOT_W-1:0] model_top;
  bit [LIM_W-1:0] model_limit = LIMIT_RESET;

  table_request_t request_queue [$];
  table_reply_t awaited_replies [$];
  table_request_t on_offer;

  int drv_gap_max = 7;
  int mon_gap_max = 7;
  int gap_left = 0;
  int stall_left = 0;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int idle_cycles = 0;
  int requests_taken = 0;
  int replies_seen = 0;
  int fault_count = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  logic [9:0] hash_pool [0:7];
  logic [KEY_W-1:0] pair_key [0:23];
  logic [HASH_W-1:0] pair_hash [0:23];

  hashed_slot_table_insert_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .in_hash_id     (in_hash_id),
    .in_slot        (in_slot),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_read_key   (out_read_key),
    .out_read_valid (out_read_valid),
    .out_top_used   (out_top_used),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Slot visited on a given attempt; a negative value means the table is full.
  function automatic longint probe_index(logic [HASH_W-1:0] h, int unsigned att, longint lim);
    longint idx;
    longint lvl;
    int unsigned w;
    idx = -1;
    w = (att >> LINE_LOG) + MIN_WIDTH;
    if (w < 40) begin
      lvl = longint'(1) << w;
      idx = ((lvl + (longint'(h) & (lvl - 1))) << LINE_LOG) + longint'(att & 3) - BIAS;
    end
    if (idx < 0 || idx >= lim) begin
      idx = lim - longint'(att);
    end
    return idx;
  endfunction

  function automatic table_reply_t apply_request(table_request_t rq);
    table_reply_t r;
    longint lim;
    longint idx;
    int unsigned att;
    bit done;
    r.status = STAT_DONE;
    r.slot_index = rq.slot;
    r.read_key = '0;
    r.read_valid = 1'b0;
    if (rq.req == REQ_INSERT) begin
      lim = longint'(model_limit);
      if (lim < 1) begin
        lim = 1;
      end
      if (lim > TABLE_SLOTS) begin
        lim = TABLE_SLOTS;
      end
      r.status = STAT_FULL;
      r.slot_index = '0;
      if (rq.key != '0) begin
        done = 1'b0;
        att = 0;
        while (!done) begin
          idx = probe_index(rq.hash, att, lim);
          if (idx < 0) begin
            done = 1'b1;
          end else if (idx < lim) begin
            if (model_keys[int'(idx)] == rq.key) begin
              r.status = STAT_PRESENT;
              r.slot_index = SLOT_W'(idx);
              done = 1'b1;
            end else if (model_keys[int'(idx)] == '0) begin
              model_keys[int'(idx)] = rq.key;
              if (idx > longint'(model_top)) begin
                model_top = SLOT_W'(idx);
              end
              r.status = STAT_NEW;
              r.slot_index = SLOT_W'(idx);
              done = 1'b1;
            end
          end
          att++;
        end
      end
    end else if (rq.req == REQ_FREE) begin
      model_keys[rq.slot] = '0;
    end else if (rq.req == REQ_READ) begin
      r.read_key = model_keys[rq.slot];
      r.read_valid = (model_keys[rq.slot] != '0);
    end
    r.top_used = model_top;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_replies.push_back(apply_request(on_offer));
        requests_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          on_offer = request_queue.pop_front();
          in_valid <= 1'b1;
          in_req_type <= on_offer.req;
          in_key <= on_offer.key;
          in_hash_id <= on_offer.hash;
          in_slot <= on_offer.slot;
          gap_left = $urandom_range(0, drv_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (awaited_replies.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("reply %0d arrived with nothing awaited: status %0d slot %0d",
                     replies_seen, out_status, out_slot_index);
          end
        end else begin
          want = awaited_replies.pop_front();
          status_tally[want.status]++;
          if (out_status !== want.status || out_slot_index !== want.slot_index ||
              out_read_key !== want.read_key || out_read_valid !== want.read_valid ||
              out_top_used !== want.top_used) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("reply %0d: expected status %0d slot %0d key %h valid %0d top %0d",
                       replies_seen, want.status, want.slot_index, want.read_key,
                       want.read_valid, want.top_used);
              $display("reply %0d:      got status %0d slot %0d key %h valid %0d top %0d",
                       replies_seen, out_status, out_slot_index, out_read_key,
                       out_read_valid, out_top_used);
            end
          end
        end
        stall_left = $urandom_range(0, mon_gap_max);
      end
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (!in_valid && awaited_replies.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_limit(logic [LIM_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    model_limit = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || awaited_replies.size() != 0);
  endtask

  task automatic push_request(req_t r, logic [KEY_W-1:0] k, logic [HASH_W-1:0] h,
                              logic [SLOT_W-1:0] s);
    table_request_t rq;
    rq.req = r;
    rq.key = k;
    rq.hash = h;
    rq.slot = s;
    request_queue.push_back(rq);
  endtask

  task automatic refresh_pools();
    for (int i = 0; i < 8; i++) begin
      hash_pool[i] = 10'($urandom);
    end
    for (int i = 0; i < 24; i++) begin
      pair_key[i] = KEY_W'({$urandom, $urandom});
      if (pair_key[i] == '0) begin
        pair_key[i] = KEY_W'(1);
      end
      if ($urandom_range(0, 1) == 0) begin
        pair_hash[i] = {21'($urandom), hash_pool[$urandom_range(0, 7)]};
      end else begin
        pair_hash[i] = HASH_W'($urandom);
      end
    end
  endtask

  // Mostly inserts that collide on a few probe chains or repeat known keys, with frees and
  // reads mostly aimed at the slots that the current limit can reach.
  function automatic table_request_t random_request(int unsigned span);
    table_request_t rq;
    int unsigned pick;
    int unsigned sel;
    int unsigned k;
    rq.key = KEY_W'({$urandom, $urandom});
    rq.hash = HASH_W'($urandom);
    rq.slot = ($urandom_range(0, 99) < 60) ? SLOT_W'($urandom_range(0, span)) : SLOT_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 52) begin
      rq.req = REQ_INSERT;
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, 23);
      if (sel < 40) begin
        rq.key = pair_key[k];
        rq.hash = pair_hash[k];
      end else if (sel < 75) begin
        rq.hash = {21'($urandom), hash_pool[$urandom_range(0, 7)]};
      end else if (sel < 78) begin
        rq.key = '0;
      end
    end else if (pick < 67) begin
      rq.req = REQ_FREE;
    end else if (pick < 94) begin
      rq.req = REQ_READ;
    end else begin
      rq.req = REQ_NONE;
    end
    return rq;
  endfunction

  initial begin
    logic [LIM_W-1:0] phase_limits [0:PHASES-1];
    int unsigned span;
    phase_limits = '{13'd4096, 13'd1, 13'd8191, 13'd16, 13'd0, 13'd1024,
                     13'd2, 13'd300, 13'd4095, 13'd4097, 13'd64, 13'd0};
    phase_limits[PHASES-1] = LIM_W'($urandom_range(1, 8191));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // A four-slot table: the fallback path, a full table, a rejected null key.
    write_limit(13'd4);
    push_request(REQ_INSERT, 48'h0000_0000_0001, 31'h0, 12'd0);
    push_request(REQ_INSERT, 48'h0000_0000_0001, 31'h0, 12'd0);
    push_request(REQ_INSERT, 48'hFFFF_FFFF_FFFF, 31'h0, 12'd0);
    push_request(REQ_INSERT, 48'h8000_0000_0000, 31'h0, 12'd0);
    push_request(REQ_INSERT, 48'h0000_1234_5678, 31'h0, 12'd0);
    push_request(REQ_INSERT, 48'hA5A5_A5A5_A5A5, 31'h7FFF_FFFF, 12'd0);
    push_request(REQ_INSERT, 48'h0, 31'h1234_5678, 12'hFFF);
    push_request(REQ_READ, 48'h0, 31'h0, 12'd0);
    push_request(REQ_READ, 48'hFFFF_FFFF_FFFF, 31'h7FFF_FFFF, 12'hFFF);
    push_request(REQ_FREE, 48'h0, 31'h0, 12'd2);
    push_request(REQ_READ, 48'h0, 31'h0, 12'd2);
    push_request(REQ_INSERT, 48'hA5A5_A5A5_A5A5, 31'h7FFF_FFFF, 12'd0);
    push_request(REQ_NONE, 48'hFFFF_FFFF_FFFF, 31'h7FFF_FFFF, 12'hFFF);
    push_request(REQ_FREE, 48'h0, 31'h0, 12'hFFF);
    wait_drained();

    // Full-size table: deep probe chains and the highest hash.
    write_limit(13'd4096);
    push_request(REQ_INSERT, 48'h5A5A_5A5A_5A5A, 31'h7FFF_FFFF, 12'd0);
    push_request(REQ_INSERT, 48'h0F0F_0F0F_0F0F, 31'h0000_03FF, 12'd0);
    push_request(REQ_INSERT, 48'hF0F0_F0F0_F0F0, 31'h0000_02FF, 12'd0);
    push_request(REQ_READ, 48'h0, 31'h0, 12'd1021);
    push_request(REQ_INSERT, 48'h5A5A_5A5A_5A5A, 31'h7FFF_FFFF, 12'd0);
    push_request(REQ_FREE, 48'h0, 31'h0, 12'd0);
    push_request(REQ_READ, 48'h0, 31'h0, 12'd0);
    push_request(REQ_READ, 48'h0, 31'h0, 12'hFFF);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_limit(phase_limits[ph]);
      drv_gap_max = (ph % 3 == 1) ? 0 : 7;
      mon_gap_max = (ph % 4 == 1) ? 0 : 7;
      refresh_pools();
      if (model_limit == 0) begin
        span = 1;
      end else if (model_limit > 1100) begin
        span = 1100;
      end else begin
        span = model_limit;
      end
      if (ph == 1) begin
        hold_request = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        request_queue.push_back(random_request(span));
        if (ph == 4 && n == PHASE_ITEMS / 2) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    fault_count += awaited_replies.size();
    $display("Covered %0d requests over %0d table limits: %0d new, %0d present, %0d full,",
             requests_taken, PHASES + 2, status_tally[STAT_NEW], status_tally[STAT_PRESENT],
             status_tally[STAT_FULL]);
    $display("%0d free, read or unused requests; %0d faults found.",
             status_tally[STAT_DONE], fault_count);
    if (fault_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/hst_pkg.sv
sv/hst_ram.sv
sv/hst_probe.sv
sv/hashed_slot_table_insert_top.sv
bench/hashed_slot_table_insert_top_test.sv
